/* hw/rtl/vibration_speed_limiter_assert.svh */
// assertion macros shared by the vibration speed limiter modules
// expects signals named clock and reset in the scope of each use
`ifndef VIBRATION_SPEED_LIMITER_ASSERT_SVH
`define VIBRATION_SPEED_LIMITER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define VSL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define VSL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/vsl_pkg.sv */
// shared types and constants for the vibration speed limiter
// no dependencies; used by the interfaces and every rtl module except vsl_sqrt
`timescale 1ns / 1ps

package vsl_pkg;

   // field widths
   localparam int POT_W     = 12;
   localparam int VIB_RAW_W = 12;
   localparam int TEMP_W    = 16;
   localparam int VIB_W     = 7;
   localparam int DRIVE_W   = 7;
   localparam int SPEED_W   = 8;
   localparam int FRAC_BITS = 16;

   // configuration register widths
   localparam int GAIN_W   = 20;
   localparam int OFFSET_W = 25;
   localparam int SCALE_W  = 16;
   localparam int THRESH_W = 7;
   localparam int LIMIT_W  = 8;
   localparam int HOLD_W   = 8;
   localparam int PERIOD_W = 6;

   // csr port
   localparam int CSR_W     = 25;
   localparam int CSR_IDX_W = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_GAIN     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_OFFSET   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VIB_SCALE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VIB_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT_PERIOD = 3'd6;

   // reset values
   localparam logic [GAIN_W-1:0]          GAIN_RST   = 20'd2560;
   localparam logic signed [OFFSET_W-1:0] OFFSET_RST = -25'sd1638400;
   localparam logic [SCALE_W-1:0]         SCALE_RST  = 16'd7537;
   localparam logic [THRESH_W-1:0]        THRESH_RST = 7'd50;
   localparam logic [LIMIT_W-1:0]         LIMIT_RST  = 8'd22;
   localparam logic [HOLD_W-1:0]          HOLD_RST   = 8'd100;
   localparam logic [PERIOD_W-1:0]        PERIOD_RST = 6'd20;

   // arithmetic constants
   localparam int HALF_LSB = 32768;
   localparam int VIB_CAP  = 100;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_DUTY,
      ST_MUL_VIB,
      ST_DUTY,
      ST_LIMIT,
      ST_SQRT,
      ST_OUT
   } vsl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_in;
      logic mul_duty;
      logic mul_vib;
      logic calc_duty;
      logic update;
      logic out_load;
   } vsl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sqrt_busy;
      logic out_free;
   } vsl_status_type;

endpackage

/* hw/rtl/vsl_if.sv */
// valid/ready channel interfaces for sample requests and responses
// depends on vsl_pkg for field widths
`timescale 1ns / 1ps

interface vsl_req_if;
   logic                               valid;
   logic                               ready;
   logic [vsl_pkg::POT_W-1:0]          pot_sample;
   logic [vsl_pkg::VIB_RAW_W-1:0]      vib_level;
   logic signed [vsl_pkg::TEMP_W-1:0]  temperature;

   modport source (output valid, output pot_sample, output vib_level, output temperature,
                   input ready);
   modport sink   (input valid, input pot_sample, input vib_level, input temperature,
                   output ready);
endinterface

interface vsl_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [vsl_pkg::DRIVE_W-1:0]        motor_drive;
   logic                               fan_on;
   logic                               report_valid;
   logic [vsl_pkg::SPEED_W-1:0]        report_speed;
   logic signed [vsl_pkg::TEMP_W-1:0]  report_temp;
   logic [vsl_pkg::VIB_W-1:0]          report_vibration;

   modport source (output valid, output motor_drive, output fan_on, output report_valid,
                   output report_speed, output report_temp, output report_vibration,
                   input ready);
   modport sink   (input valid, input motor_drive, input fan_on, input report_valid,
                   input report_speed, input report_temp, input report_vibration,
                   output ready);
endinterface

/* hw/rtl/vsl_sqrt.sv */
// iterative square root, one result bit per cycle, rounded to nearest
// standalone; uses the assertion macro header
`timescale 1ns / 1ps
`include "vibration_speed_limiter_assert.svh"

module vsl_sqrt #(
   parameter int RAD_W = 14
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [RAD_W-1:0]          radicand,
   output logic                      busy,
   output logic [(RAD_W+1)/2:0]      root
);

   localparam int RT_W  = (RAD_W + 1) / 2;
   localparam int X_W   = 2 * RT_W;
   localparam int REM_W = RT_W + 3;
   localparam int CNT_W = $clog2(RT_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [X_W-1:0]    x_ff, x_in;
   logic [REM_W-1:0]  r_ff, r_in;
   logic [RT_W-1:0]   q_ff, q_in;
   logic [REM_W-1:0]  r_sh;
   logic [REM_W-1:0]  trial;

   // one restoring step: bring down two bits, try subtracting 4q+1
   always_comb begin
      r_sh    = {r_ff[RT_W:0], x_ff[X_W-1 -: 2]};
      trial   = REM_W'({q_ff, 2'b01});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RT_W);
         x_in    = X_W'(radicand);
         r_in    = '0;
         q_in    = '0;
      end else if (busy_ff) begin
         x_in    = {x_ff[X_W-3:0], 2'b00};
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(1));
         if (r_sh >= trial) begin
            r_in = r_sh - trial;
            q_in = {q_ff[RT_W-2:0], 1'b1};
         end else begin
            r_in = r_sh;
            q_in = {q_ff[RT_W-2:0], 1'b0};
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;
      r_ff <= r_in;
      q_ff <= q_in;
   end

   // remainder above q means x > q*q + q, so round up
   assign busy = busy_ff;
   assign root = (r_ff > REM_W'(q_ff)) ? ((RT_W+1)'(q_ff) + (RT_W+1)'(1)) : (RT_W+1)'(q_ff);

   `VSL_ASSERT_SAME(a_sqrt_count_live, busy_ff, cnt_ff != '0, "sqrt busy with zero count")

endmodule

/* hw/rtl/vsl_datapath.sv */
// datapath: config registers, shared multiplier, duty/vibration scaling,
// limiter state, square root unit and output register; uses vsl_pkg and vsl_sqrt
`timescale 1ns / 1ps
`include "vibration_speed_limiter_assert.svh"

module vsl_datapath #(
   parameter int ADC_BITS  = 12,
   parameter int DUTY_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [vsl_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [vsl_pkg::CSR_W-1:0]            csr_wdata,
   input  logic [vsl_pkg::POT_W-1:0]            pot_sample,
   input  logic [vsl_pkg::VIB_RAW_W-1:0]        vib_level,
   input  logic signed [vsl_pkg::TEMP_W-1:0]    temperature,
   input  vsl_pkg::vsl_cmd_type                 cmd,
   output vsl_pkg::vsl_status_type              sts,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic [vsl_pkg::DRIVE_W-1:0]          motor_drive,
   output logic                                 fan_on,
   output logic                                 report_valid,
   output logic [vsl_pkg::SPEED_W-1:0]          report_speed,
   output logic signed [vsl_pkg::TEMP_W-1:0]    report_temp,
   output logic [vsl_pkg::VIB_W-1:0]            report_vibration
);

   localparam int POT_KEEP = (ADC_BITS < vsl_pkg::POT_W) ? ADC_BITS : vsl_pkg::POT_W;
   localparam int OP_B_W = (vsl_pkg::POT_W > vsl_pkg::VIB_RAW_W) ? vsl_pkg::POT_W
                                                                 : vsl_pkg::VIB_RAW_W;
   localparam int PROD_W = vsl_pkg::GAIN_W + OP_B_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int DV_W   = PROD_W + 1 - vsl_pkg::FRAC_BITS;
   localparam int DL_W   = (DUTY_BITS > vsl_pkg::SPEED_W) ? DUTY_BITS : vsl_pkg::SPEED_W;
   localparam int RAD_W  = DUTY_BITS + 6;
   localparam int RT_W   = (RAD_W + 1) / 2;

   // configuration registers
   logic [vsl_pkg::GAIN_W-1:0]          gain_ff;
   logic signed [vsl_pkg::OFFSET_W-1:0] offset_ff;
   logic [vsl_pkg::SCALE_W-1:0]         scale_ff;
   logic [vsl_pkg::THRESH_W-1:0]        thresh_ff;
   logic [vsl_pkg::LIMIT_W-1:0]         limit_ff;
   logic [vsl_pkg::HOLD_W-1:0]          hold_ticks_ff;
   logic [vsl_pkg::PERIOD_W-1:0]        period_ff;

   // sample registers
   logic [vsl_pkg::POT_W-1:0]           pot_ff;
   logic [vsl_pkg::VIB_RAW_W-1:0]       vraw_ff;
   logic signed [vsl_pkg::TEMP_W-1:0]   temp_ff;

   // arithmetic
   logic [vsl_pkg::GAIN_W-1:0]          op_a;
   logic [OP_B_W-1:0]                   op_b;
   logic [PROD_W-1:0]                   prod_in, prod_ff;
   logic signed [ACC_W-1:0]             acc_in, acc_ff;
   logic                                acc_low;
   logic [PROD_W:0]                     duty_sum, vib_sum;
   logic [DV_W-1:0]                     duty_raw, vib_raw;
   logic [DUTY_BITS-1:0]                duty_in, duty_ff;
   logic [vsl_pkg::VIB_W-1:0]           vib_in, vib_ff;

   // limiter state
   logic [vsl_pkg::HOLD_W-1:0]          hold_ff, hold_in;
   logic                                fan_ff, fan_in;
   logic [vsl_pkg::PERIOD_W-1:0]        sample_ff, sample_in;
   logic                                vib_high, over, report;
   logic [DL_W-1:0]                     duty_ext, limit_ext;
   logic [DUTY_BITS-1:0]                lim;
   logic [RAD_W-1:0]                    radicand;

   // report registers
   logic                                rep_valid_ff;
   logic [vsl_pkg::SPEED_W-1:0]         rep_speed_ff;
   logic signed [vsl_pkg::TEMP_W-1:0]   rep_temp_ff;
   logic [vsl_pkg::VIB_W-1:0]           rep_vib_ff;

   // square root
   logic                                sqrt_busy;
   logic [RT_W:0]                       root;

   // output register
   logic                                rsp_valid_ff;
   logic [vsl_pkg::DRIVE_W-1:0]         drive_out_ff;
   logic                                fan_out_ff;
   logic                                rep_valid_out_ff;
   logic [vsl_pkg::SPEED_W-1:0]         rep_speed_out_ff;
   logic signed [vsl_pkg::TEMP_W-1:0]   rep_temp_out_ff;
   logic [vsl_pkg::VIB_W-1:0]           rep_vib_out_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= vsl_pkg::GAIN_RST;
         offset_ff     <= vsl_pkg::OFFSET_RST;
         scale_ff      <= vsl_pkg::SCALE_RST;
         thresh_ff     <= vsl_pkg::THRESH_RST;
         limit_ff      <= vsl_pkg::LIMIT_RST;
         hold_ticks_ff <= vsl_pkg::HOLD_RST;
         period_ff     <= vsl_pkg::PERIOD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            vsl_pkg::CSR_DUTY_GAIN:     gain_ff       <= csr_wdata[vsl_pkg::GAIN_W-1:0];
            vsl_pkg::CSR_DUTY_OFFSET:   offset_ff     <= $signed(csr_wdata[vsl_pkg::OFFSET_W-1:0]);
            vsl_pkg::CSR_VIB_SCALE:     scale_ff      <= csr_wdata[vsl_pkg::SCALE_W-1:0];
            vsl_pkg::CSR_VIB_THRESHOLD: thresh_ff     <= csr_wdata[vsl_pkg::THRESH_W-1:0];
            vsl_pkg::CSR_SPEED_LIMIT:   limit_ff      <= csr_wdata[vsl_pkg::LIMIT_W-1:0];
            vsl_pkg::CSR_HOLD_TICKS:    hold_ticks_ff <= csr_wdata[vsl_pkg::HOLD_W-1:0];
            vsl_pkg::CSR_REPORT_PERIOD: period_ff     <= csr_wdata[vsl_pkg::PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier: gain*pot first, then vibration*scale
   always_comb begin
      op_a    = cmd.mul_vib ? vsl_pkg::GAIN_W'(scale_ff) : gain_ff;
      op_b    = cmd.mul_vib ? OP_B_W'(vraw_ff) : OP_B_W'(pot_ff);
      prod_in = PROD_W'(op_a) * PROD_W'(op_b);
      acc_in  = $signed({2'b00, prod_ff}) + ACC_W'(offset_ff);
   end

   // duty rounding and saturation, vibration rounding and cap
   always_comb begin
      acc_low  = (acc_ff < $signed(ACC_W'(vsl_pkg::HALF_LSB)));
      duty_sum = acc_ff[PROD_W:0] + (PROD_W+1)'(vsl_pkg::HALF_LSB);
      duty_raw = duty_sum[PROD_W:vsl_pkg::FRAC_BITS];
      if (acc_low) begin
         duty_in = '0;
      end else if (|duty_raw[DV_W-1:DUTY_BITS]) begin
         duty_in = '1;
      end else begin
         duty_in = duty_raw[DUTY_BITS-1:0];
      end
      vib_sum = (PROD_W+1)'(prod_ff) + (PROD_W+1)'(vsl_pkg::HALF_LSB);
      vib_raw = vib_sum[PROD_W:vsl_pkg::FRAC_BITS];
      if (vib_raw > DV_W'(vsl_pkg::VIB_CAP)) begin
         vib_in = vsl_pkg::VIB_W'(vsl_pkg::VIB_CAP);
      end else begin
         vib_in = vib_raw[vsl_pkg::VIB_W-1:0];
      end
   end

   // speed limiting, hold timer, fan and report counter
   always_comb begin
      duty_ext  = DL_W'(duty_ff);
      limit_ext = DL_W'(limit_ff);
      vib_high  = (vib_ff >= thresh_ff);
      over      = (duty_ext > limit_ext);
      lim       = duty_ff;
      hold_in   = hold_ff;
      fan_in    = fan_ff;
      if (vib_high) begin
         if (over) begin
            lim     = limit_ext[DUTY_BITS-1:0];
            hold_in = hold_ticks_ff;
         end
         fan_in = 1'b1;
      end else begin
         if (hold_ff != '0) begin
            if (over) begin
               lim = limit_ext[DUTY_BITS-1:0];
            end else begin
               hold_in = hold_ff - vsl_pkg::HOLD_W'(1);
            end
         end
         if (hold_in == '0) begin
            fan_in = 1'b0;
         end
      end
      report    = (sample_ff == period_ff);
      sample_in = report ? vsl_pkg::PERIOD_W'(1) : sample_ff + vsl_pkg::PERIOD_W'(1);
      radicand  = RAD_W'({lim, 5'b00000}) + RAD_W'({lim, 2'b00});
   end

   // limiter state and output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff      <= '0;
         fan_ff       <= 1'b0;
         sample_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            hold_ff   <= hold_in;
            fan_ff    <= fan_in;
            sample_ff <= sample_in;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         pot_ff  <= vsl_pkg::POT_W'(pot_sample[POT_KEEP-1:0]);
         vraw_ff <= vib_level;
         temp_ff <= temperature;
      end
      if (cmd.mul_duty || cmd.mul_vib) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_vib) begin
         acc_ff <= acc_in;
      end
      if (cmd.calc_duty) begin
         duty_ff <= duty_in;
         vib_ff  <= vib_in;
      end
      if (cmd.update) begin
         rep_valid_ff <= report;
         rep_speed_ff <= report ? duty_ext[vsl_pkg::SPEED_W-1:0] : '0;
         rep_temp_ff  <= report ? temp_ff : '0;
         rep_vib_ff   <= report ? vib_ff : '0;
      end
      if (cmd.out_load) begin
         drive_out_ff     <= root[vsl_pkg::DRIVE_W-1:0];
         fan_out_ff       <= fan_ff;
         rep_valid_out_ff <= rep_valid_ff;
         rep_speed_out_ff <= rep_speed_ff;
         rep_temp_out_ff  <= rep_temp_ff;
         rep_vib_out_ff   <= rep_vib_ff;
      end
   end

   // motor drive square root
   vsl_sqrt #(
      .RAD_W (RAD_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.update),
      .radicand (radicand),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // status and response
   assign sts.sqrt_busy    = sqrt_busy;
   assign sts.out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign motor_drive      = drive_out_ff;
   assign fan_on           = fan_out_ff;
   assign report_valid     = rep_valid_out_ff;
   assign report_speed     = rep_speed_out_ff;
   assign report_temp      = rep_temp_out_ff;
   assign report_vibration = rep_vib_out_ff;

   `VSL_ASSERT_NEXT(a_report_restarts_count, cmd.update && report, sample_ff == vsl_pkg::PERIOD_W'(1), "report did not restart sample count")
   `VSL_ASSERT_NEXT(a_hold_arms_fan, cmd.update && vib_high, fan_ff, "fan off after high vibration")

endmodule

/* hw/rtl/vsl_ctrl.sv */
// controller state machine sequencing the datapath for one sample
// uses vsl_pkg types and the assertion macro header
`timescale 1ns / 1ps
`include "vibration_speed_limiter_assert.svh"

module vsl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  vsl_pkg::vsl_status_type  sts,
   output vsl_pkg::vsl_cmd_type     cmd
);

   vsl_pkg::vsl_state_type st_ff, st_in;

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         vsl_pkg::ST_IDLE:     if (req_valid) st_in = vsl_pkg::ST_MUL_DUTY;
         vsl_pkg::ST_MUL_DUTY: st_in = vsl_pkg::ST_MUL_VIB;
         vsl_pkg::ST_MUL_VIB:  st_in = vsl_pkg::ST_DUTY;
         vsl_pkg::ST_DUTY:     st_in = vsl_pkg::ST_LIMIT;
         vsl_pkg::ST_LIMIT:    st_in = vsl_pkg::ST_SQRT;
         vsl_pkg::ST_SQRT:     if (!sts.sqrt_busy) st_in = vsl_pkg::ST_OUT;
         vsl_pkg::ST_OUT:      if (sts.out_free) st_in = vsl_pkg::ST_IDLE;
         default:              st_in = vsl_pkg::ST_IDLE;
      endcase
   end

   // datapath commands; no request transfer while in reset
   always_comb begin
      req_ready     = (st_ff == vsl_pkg::ST_IDLE) && !reset;
      cmd.load_in   = (st_ff == vsl_pkg::ST_IDLE) && req_valid && !reset;
      cmd.mul_duty  = (st_ff == vsl_pkg::ST_MUL_DUTY);
      cmd.mul_vib   = (st_ff == vsl_pkg::ST_MUL_VIB);
      cmd.calc_duty = (st_ff == vsl_pkg::ST_DUTY);
      cmd.update    = (st_ff == vsl_pkg::ST_LIMIT);
      cmd.out_load  = (st_ff == vsl_pkg::ST_OUT) && sts.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= vsl_pkg::ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   `VSL_ASSERT_SAME(a_out_load_free, cmd.out_load, sts.out_free, "output register loaded while occupied")
   `VSL_ASSERT_NEXT(a_sqrt_started, st_ff == vsl_pkg::ST_LIMIT, sts.sqrt_busy, "square root not started after limit step")

endmodule

/* hw/rtl/vibration_speed_limiter.sv */
// Vibration speed limiter top level: wires controller and datapath to the channels.
// Depends on vsl_pkg, vsl_if, vsl_ctrl and vsl_datapath.
//
// Usage:
//   req_if carries one sample (pot_sample, vib_level, temperature) per transfer;
//   rsp_if returns exactly one result per sample, in order.
//   csr_wr_en/csr_index/csr_wdata write the seven configuration registers;
//   write only while no sample is in flight. Indexes past the list are ignored.
// Timing:
//   after a request transfer the controller steps through the gain multiply,
//   the vibration multiply with offset add, duty and vibration rounding and
//   the limit step, then waits in the bit-serial square root (one bit per
//   cycle) and loads the output register once it is free; the next request is
//   taken only after that load, as multiplier and root are not overlapped.
// Reset:
//   synchronous, active high; restores register defaults and clears the hold
//   timer, fan state and report counter.
// Backpressure:
//   the response register holds its result while rsp_if.ready is low; the
//   next sample is still accepted and waits at the output load step.
`timescale 1ns / 1ps

module vibration_speed_limiter #(
   parameter int ADC_BITS  = 12,
   parameter int DUTY_BITS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   vsl_req_if.sink                        req_if,
   vsl_rsp_if.source                      rsp_if,
   input  logic                           csr_wr_en,
   input  logic [vsl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [vsl_pkg::CSR_W-1:0]      csr_wdata
);

   vsl_pkg::vsl_cmd_type    cmd;
   vsl_pkg::vsl_status_type sts;

   // sequencing
   vsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic and state
   vsl_datapath #(
      .ADC_BITS  (ADC_BITS),
      .DUTY_BITS (DUTY_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .pot_sample       (req_if.pot_sample),
      .vib_level        (req_if.vib_level),
      .temperature      (req_if.temperature),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_if.ready),
      .rsp_valid        (rsp_if.valid),
      .motor_drive      (rsp_if.motor_drive),
      .fan_on           (rsp_if.fan_on),
      .report_valid     (rsp_if.report_valid),
      .report_speed     (rsp_if.report_speed),
      .report_temp      (rsp_if.report_temp),
      .report_vibration (rsp_if.report_vibration)
   );

endmodule
